// ===== rtl/core/sawbc_pkg.sv =====
package sawbc_pkg;
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_PROBE = 2'd0;
    localparam t_cmd CMD_READ  = 2'd1;
    localparam t_cmd CMD_WRITE = 2'd2;
    localparam t_cmd CMD_FILL  = 2'd3;
    localparam int ADDR_W = 32;
    localparam int WORD_W = 32;
    localparam int BYTE_OFF_W = 2;
endpackage

// ===== rtl/core/set_assoc_write_back_cache_top.sv =====
// Probe, read and write go through a memory read, then update and result.
// An installing fill adds a victim read, a result (one per word for a dirty victim)
// and a block write.
// Throughput: one item in flight; busy stays high until the item's last cycle.
// Reset: synchronous active low, then a clearing pass over all SET_COUNT sets with busy high.
// Results cannot be stalled by the receiver.
module set_assoc_write_back_cache_top #(
    parameter int SET_COUNT = 16,
    parameter int WAY_COUNT = 4,
    parameter int BLOCK_WORDS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  sawbc_pkg::t_cmd           i_command,
    input  logic [31:0]               i_address,
    input  logic [31:0]               i_write_data,
    input  logic                      i_dirty_flag,
    input  logic                      i_fill_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_replacement_mode,
    output logic                      o_strobe,
    output logic                      o_hit,
    output logic [31:0]               o_read_data,
    output logic                      o_evicted,
    output logic [31:0]               o_evict_address,
    output logic [31:0]               o_evict_data,
    output logic                      o_last
);
    import sawbc_pkg::*;

    localparam int OB = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 0;
    localparam int IB = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 0;
    localparam int OW = (OB > 0) ? OB : 1;
    localparam int IW = (IB > 0) ? IB : 1;
    localparam int WW = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int TSH = BYTE_OFF_W + OB + IB;
    localparam int TW = ADDR_W - TSH;
    localparam int AW = (WAY_COUNT > 1) ? $clog2(WAY_COUNT + 1) : 1;
    localparam int NROW = SET_COUNT * BLOCK_WORDS;
    localparam int RW = (NROW > 1) ? $clog2(NROW) : 1;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_GATH = 3'd3;
    localparam logic [2:0] ST_EVIC = 3'd4;
    localparam logic [2:0] ST_INST = 3'd5;

    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic [TW-1:0] tag;
        logic [AW-1:0] age;
    } t_meta;

    t_meta [WAY_COUNT-1:0]            r_meta [SET_COUNT];
    t_meta [WAY_COUNT-1:0]            r_meta_rd;
    logic [WAY_COUNT-1:0][WORD_W-1:0] r_words [NROW];
    logic [WORD_W-1:0]                r_fbuf [BLOCK_WORDS];

    logic [2:0]           r_state;
    logic [IW-1:0]        r_clr;
    logic                 r_mode;
    t_cmd                 r_cmd;
    logic [TW-1:0]        r_tag;
    logic [IW-1:0]        r_set;
    logic [OW-1:0]        r_off;
    logic [WORD_W-1:0]    r_wdata;
    logic                 r_dflag;
    logic                 r_flast;
    logic [WAY_COUNT-1:0][WORD_W-1:0] r_rdword;
    logic [OW-1:0]        r_cnt;
    logic [WW-1:0]        r_tgt;
    logic                 r_tvalid;
    logic [WORD_W-1:0]    r_evw [BLOCK_WORDS];

    logic [OW-1:0]        w_off;
    logic [IW-1:0]        w_set;
    t_meta                w_set_meta [WAY_COUNT];
    logic                 w_hit;
    logic [WW-1:0]        w_hway;
    logic                 w_inv_found;
    logic [WW-1:0]        w_inv_way;
    logic [AW-1:0]        w_best;
    logic [WW-1:0]        w_best_way;
    logic [RW-1:0]        w_rd_row;
    logic                 w_dirty_victim;
    logic                 w_evic_end;
    logic                 w_look_done;

    logic                 w_meta_we;
    logic [IW-1:0]        w_meta_addr;
    t_meta [WAY_COUNT-1:0] w_meta_row;

    function automatic logic [OW-1:0] f_off(input logic [31:0] a);
        logic [OW:0] v;
        v = '0;
        if (OB > 0) v[OW-1:0] = a[BYTE_OFF_W +: OW];
        if (v >= (OW+1)'(BLOCK_WORDS)) v = v - (OW+1)'(BLOCK_WORDS);
        return v[OW-1:0];
    endfunction

    function automatic logic [IW-1:0] f_set(input logic [31:0] a);
        logic [IW:0] v;
        v = '0;
        if (IB > 0) v[IW-1:0] = a[BYTE_OFF_W + OB +: IW];
        if (v >= (IW+1)'(SET_COUNT)) v = v - (IW+1)'(SET_COUNT);
        return v[IW-1:0];
    endfunction

    assign w_off = f_off(i_address);
    assign w_set = f_set(i_address);

    always_comb begin
        for (int w = 0; w < WAY_COUNT; w++) w_set_meta[w] = r_meta_rd[w];
        w_hit = 1'b0;
        w_hway = '0;
        w_inv_found = 1'b0;
        w_inv_way = '0;
        w_best = '0;
        w_best_way = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (w_set_meta[w].valid && w_set_meta[w].tag == r_tag) begin
                w_hit = 1'b1;
                w_hway = WW'(w);
            end
            if (!w_set_meta[w].valid) begin
                w_inv_found = 1'b1;
                w_inv_way = WW'(w);
            end
        end
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (w_set_meta[w].age > w_best) begin
                w_best = w_set_meta[w].age;
                w_best_way = WW'(w);
            end
        end
    end

    assign busy = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    assign w_dirty_victim = r_tvalid && w_set_meta[r_tgt].dirty;
    assign w_evic_end = !w_dirty_victim || (32'(r_cnt) == BLOCK_WORDS - 1);
    assign w_look_done = !(r_cmd == CMD_FILL && r_flast && !w_hit);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) r_meta_rd <= r_meta[w_set];
        if (w_meta_we) r_meta[w_meta_addr] <= w_meta_row;
    end

    always_comb begin
        w_meta_we = 1'b0;
        w_meta_addr = r_set;
        w_meta_row = r_meta_rd;
        case (r_state)
            ST_CLR: begin
                w_meta_we = 1'b1;
                w_meta_addr = r_clr;
                w_meta_row = '0;
            end
            ST_LOOK: begin
                if (r_cmd == CMD_READ && w_hit && r_mode) begin
                    w_meta_we = 1'b1;
                    for (int w = 0; w < WAY_COUNT; w++) begin
                        if (WW'(w) == w_hway) w_meta_row[w].age = '0;
                        else if (w_set_meta[w].valid &&
                                 w_set_meta[w].age < w_set_meta[w_hway].age)
                            w_meta_row[w].age = w_set_meta[w].age + 1'b1;
                    end
                end else if (r_cmd == CMD_WRITE && w_hit) begin
                    w_meta_we = 1'b1;
                    w_meta_row[w_hway].dirty = r_dflag;
                end
            end
            ST_EVIC: begin
                if (w_evic_end) begin
                    w_meta_we = 1'b1;
                    for (int w = 0; w < WAY_COUNT; w++) begin
                        if (WW'(w) == r_tgt) begin
                            w_meta_row[w].age = '0;
                            w_meta_row[w].valid = 1'b1;
                            w_meta_row[w].dirty = r_dflag;
                            w_meta_row[w].tag = r_tag;
                        end else if (w_set_meta[w].valid &&
                                     (!r_tvalid ||
                                      w_set_meta[w].age < w_set_meta[r_tgt].age)) begin
                            w_meta_row[w].age = w_set_meta[w].age + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_rd_row = RW'(32'(w_set) * 32'(BLOCK_WORDS) + 32'(w_off));
    end

    always_ff @(posedge i_clk) begin
        r_rdword <= r_words[w_rd_row];
    end

    logic [RW-1:0] w_wr_row;
    logic [WW-1:0] w_wr_way;
    logic [WORD_W-1:0] w_wr_data;
    logic w_wr_en;
    logic [WORD_W-1:0] r_gword;
    logic [RW-1:0] w_g_row;

    assign w_g_row = RW'(32'(r_set) * 32'(BLOCK_WORDS) + 32'(r_cnt));

    always_ff @(posedge i_clk) begin
        if (r_state == ST_GATH) r_gword <= r_words[w_g_row][r_tgt];
        if (w_wr_en) r_words[w_wr_row][w_wr_way] <= w_wr_data;
    end

    always_comb begin
        w_wr_en = 1'b0;
        w_wr_row = w_g_row;
        w_wr_way = r_tgt;
        w_wr_data = r_fbuf[r_cnt];
        if (r_state == ST_CLR) begin
            w_wr_en = 1'b0;
        end else if (r_state == ST_LOOK && r_cmd == CMD_WRITE && w_hit) begin
            w_wr_en = 1'b1;
            w_wr_row = RW'(32'(r_set) * 32'(BLOCK_WORDS) + 32'(r_off));
            w_wr_way = w_hway;
            w_wr_data = r_wdata;
        end else if (r_state == ST_INST) begin
            w_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr <= '0;
            r_mode <= 1'b1;
            o_strobe <= 1'b0;
            o_last <= 1'b0;
            o_hit <= 1'b0;
            o_read_data <= '0;
            o_evicted <= 1'b0;
            o_evict_address <= '0;
            o_evict_data <= '0;
        end else begin
            case (r_state)
                ST_CLR: begin
                    o_strobe <= 1'b0;
                    o_last <= 1'b0;
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == SET_COUNT - 1) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    o_strobe <= 1'b0;
                    o_last <= 1'b0;
                    if (i_cfg_valid) r_mode <= i_cfg_replacement_mode;
                    if (start) begin
                        r_cmd <= i_command;
                        r_tag <= i_address[ADDR_W-1 -: TW];
                        r_set <= w_set;
                        r_off <= w_off;
                        r_wdata <= i_write_data;
                        r_dflag <= i_dirty_flag;
                        r_flast <= i_fill_last;
                        r_cnt <= '0;
                        if (i_command == CMD_FILL) r_fbuf[w_off] <= i_write_data;
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    o_hit <= w_hit;
                    o_read_data <= (r_cmd == CMD_READ && w_hit) ? r_rdword[w_hway] : '0;
                    o_evicted <= 1'b0;
                    o_evict_address <= '0;
                    o_evict_data <= '0;
                    o_strobe <= w_look_done;
                    o_last <= w_look_done;
                    if (w_look_done) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_tgt <= w_inv_found ? w_inv_way : w_best_way;
                        r_tvalid <= !w_inv_found;
                        r_state <= ST_GATH;
                    end
                end
                ST_GATH: begin
                    o_strobe <= 1'b0;
                    o_last <= 1'b0;
                    // r_gword is registered, so it holds the word for the previous r_cnt
                    if (r_cnt != '0) r_evw[r_cnt - 1'b1] <= r_gword;
                    if (32'(r_cnt) == BLOCK_WORDS - 1) begin
                        r_cnt <= '0;
                        r_state <= ST_EVIC;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_EVIC: begin
                    o_strobe <= 1'b1;
                    o_hit <= 1'b0;
                    o_read_data <= '0;
                    o_evicted <= w_dirty_victim;
                    if (w_dirty_victim) begin
                        o_evict_address <= (ADDR_W'(w_set_meta[r_tgt].tag) << TSH)
                                           | (ADDR_W'(r_set) << (BYTE_OFF_W + OB));
                        o_evict_data <= (32'(r_cnt) == BLOCK_WORDS - 1) ? r_gword
                                                                          : r_evw[r_cnt];
                    end else begin
                        o_evict_address <= '0;
                        o_evict_data <= '0;
                    end
                    o_last <= w_evic_end;
                    if (w_evic_end) begin
                        r_cnt <= '0;
                        r_state <= ST_INST;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_INST: begin
                    o_strobe <= 1'b0;
                    o_last <= 1'b0;
                    if (32'(r_cnt) == BLOCK_WORDS - 1) begin
                        r_cnt <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    o_strobe <= 1'b0;
                    o_last <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
